// File: src/hfc_pkg.sv
// Shared types and constants for the hex fingerprint compare block.
// Used by hfc_ctrl, hfc_datapath and hex_fingerprint_compare_top; no dependencies.
`default_nettype none

package hfc_pkg;

    // mode register codes
    localparam logic [2:0] MODE_VALID     = 3'd0;
    localparam logic [2:0] MODE_POPCOUNT  = 3'd1;
    localparam logic [2:0] MODE_INTERSECT = 3'd2;
    localparam logic [2:0] MODE_TANIMOTO  = 3'd3;
    localparam logic [2:0] MODE_SUBSET    = 3'd4;
    localparam logic [2:0] MODE_RESET     = MODE_TANIMOTO;

    localparam int CHAR_W    = 8;
    localparam int DEC_W     = 5;   // decoded nibble, 16 means bad character
    localparam int NIB_POP_W = 3;
    localparam int FRAC_BITS = 16;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int CNT_OUT_W = 15;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [DEC_W-1:0] DEC_BAD = 5'd16;

    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic last;       // accepted item closes the run
        logic div_step;   // advance divider by one quotient bit
        logic out_load;   // move finished result into output register
    } hfc_cmd_t;

    typedef struct packed {
        logic skip_div;   // finished run needs no quotient
    } hfc_status_t;

    function automatic logic [DEC_W-1:0] decode_hex(input logic [CHAR_W-1:0] c);
        logic [DEC_W-1:0] d;
        d = DEC_BAD;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = DEC_W'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = DEC_W'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = DEC_W'(c - 8'h57);
        end
        return d;
    endfunction

    function automatic logic [NIB_POP_W-1:0] nib_pop(input logic [3:0] v);
        return NIB_POP_W'(v[0]) + NIB_POP_W'(v[1]) + NIB_POP_W'(v[2]) + NIB_POP_W'(v[3]);
    endfunction

endpackage

`default_nettype wire

// File: src/hex_fingerprint_compare_top.sv
// Top level of the hex fingerprint compare block.
// Instantiates hfc_ctrl and hfc_datapath; depends on hfc_pkg.
//
//  channel  | direction | tdata fields (low bit up)                          | tlast
//  s_       | in        | first_char[7:0], second_char[15:8]                 | last
//  m_       | out       | invalid[0], bit_count[15:1], similarity[32:16],    | -
//           |           | is_subset[33], zero pad[39:34]                     |
//  cfg_     | in        | cfg_wdata = mode, written when cfg_we is high      | -
//
// Character pairs are taken one per cycle while a run is open. The item with tlast
// closes the run; then the restoring divider runs in Tanimoto mode with a valid,
// nonempty union (it is skipped otherwise), and the result is then moved to the
// output register.
// s_tready stays low from the tlast transfer until the result is loaded, and longer
// while the output register is still full.
// Reset is synchronous on aresetn and sets mode to Tanimoto.
`default_nettype none

module hex_fingerprint_compare_top #(
    parameter int MAX_CHARS = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,     // mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,       // first_char[7:0], second_char[15:8]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata        // invalid, bit_count, similarity, is_subset, pad
);

    hfc_pkg::hfc_cmd_t    cmd;
    hfc_pkg::hfc_status_t status;

    logic                              invalid;
    logic [hfc_pkg::CNT_OUT_W-1:0]     bit_count;
    logic [hfc_pkg::QUO_W-1:0]         similarity;
    logic                              is_subset;

    hfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hfc_datapath #(
        .MAX_CHARS (MAX_CHARS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .first_char  (s_tdata[7:0]),
        .second_char (s_tdata[15:8]),
        .cmd         (cmd),
        .status      (status),
        .invalid     (invalid),
        .bit_count   (bit_count),
        .similarity  (similarity),
        .is_subset   (is_subset)
    );

    assign m_tdata = {6'd0, is_subset, similarity, bit_count, invalid};

endmodule

`default_nettype wire

// File: src/hfc_ctrl.sv
// Controller for the hex fingerprint compare block: run, divide and hand-off states.
// Depends on hfc_pkg for command and status structs.
`default_nettype none

module hfc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tlast,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire hfc_pkg::hfc_status_t status,
    output hfc_pkg::hfc_cmd_t      cmd
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    localparam logic [hfc_pkg::STEP_W-1:0] STEP_LAST =
        hfc_pkg::STEP_W'(hfc_pkg::DIV_STEPS - 1);

    logic [1:0]                  state_reg, state_next;
    logic [hfc_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        out_free;

    assign s_tready = (state_reg == ST_RUN);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd.accept   = s_tvalid && (state_reg == ST_RUN);
        cmd.last     = s_tlast;
        cmd.div_step = (state_reg == ST_DIV) && !status.skip_div;
        cmd.out_load = (state_reg == ST_WAIT) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_RUN: begin
                step_next = '0;
                if (cmd.accept && s_tlast) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // skip the quotient when the mode or the run makes it unused
                if (status.skip_div || step_reg == STEP_LAST) begin
                    state_next = ST_WAIT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// File: src/hfc_datapath.sv
// Datapath for the hex fingerprint compare block: decode, run totals, restoring divider
// and output register. Depends on hfc_pkg; driven by hfc_ctrl commands.
`default_nettype none

module hfc_datapath #(
    parameter int MAX_CHARS = 4096
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_wdata,
    input  wire logic [hfc_pkg::CHAR_W-1:0] first_char,
    input  wire logic [hfc_pkg::CHAR_W-1:0] second_char,
    input  wire hfc_pkg::hfc_cmd_t    cmd,
    output hfc_pkg::hfc_status_t      status,
    output logic                      invalid,
    output logic [hfc_pkg::CNT_OUT_W-1:0] bit_count,
    output logic [hfc_pkg::QUO_W-1:0] similarity,
    output logic                      is_subset
);

    localparam int CNT_W   = $clog2(4 * MAX_CHARS + 1);
    localparam int WIDE_W  = (CNT_W > hfc_pkg::CNT_OUT_W) ? CNT_W : hfc_pkg::CNT_OUT_W;
    localparam logic [CNT_W:0] LIMIT = (CNT_W + 1)'(4 * MAX_CHARS);

    logic [2:0] mode_reg;

    // run totals
    logic             bad_reg, bad_next;
    logic             first_bad_reg, first_bad_next;
    logic [CNT_W-1:0] first_total_reg, first_total_next;
    logic [CNT_W-1:0] union_reg, union_next;
    logic [CNT_W-1:0] common_reg, common_next;
    logic             broken_reg, broken_next;
    logic             bab_reg, bab_next;

    // finished run snapshot
    logic [2:0]       fin_mode_reg;
    logic             fin_bad_reg, fin_first_bad_reg, fin_broken_reg, fin_bab_reg;
    logic [CNT_W-1:0] fin_first_total_reg, fin_common_reg, fin_union_reg;

    // divider
    logic [CNT_W:0]              rem_reg, rem_next;
    logic [hfc_pkg::QUO_W-1:0]   quo_reg;
    logic                        quo_bit;
    logic [CNT_W:0]              rem_sub;

    logic [hfc_pkg::DEC_W-1:0]     q_dec, t_dec;
    logic                          q_bad, t_bad;
    logic [hfc_pkg::NIB_POP_W-1:0] q_pop, or_pop, and_pop;

    logic                          res_inv, res_sub;
    logic [hfc_pkg::CNT_OUT_W-1:0] res_cnt;
    logic [hfc_pkg::QUO_W-1:0]     res_sim;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
                                                  input logic [hfc_pkg::NIB_POP_W-1:0] inc);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(acc) + (CNT_W + 1)'(inc);
        if (s > LIMIT) begin
            s = LIMIT;
        end
        return s[CNT_W-1:0];
    endfunction

    function automatic logic [hfc_pkg::CNT_OUT_W-1:0] to_out(input logic [CNT_W-1:0] v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return w[hfc_pkg::CNT_OUT_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= hfc_pkg::MODE_RESET;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    always_comb begin
        q_dec   = hfc_pkg::decode_hex(first_char);
        t_dec   = hfc_pkg::decode_hex(second_char);
        q_bad   = q_dec[4];
        t_bad   = t_dec[4];
        q_pop   = hfc_pkg::nib_pop(q_dec[3:0]);
        or_pop  = hfc_pkg::nib_pop(q_dec[3:0] | t_dec[3:0]);
        and_pop = hfc_pkg::nib_pop(q_dec[3:0] & t_dec[3:0]);

        bad_next         = bad_reg || q_bad || t_bad;
        first_bad_next   = first_bad_reg || q_bad;
        first_total_next = q_bad ? first_total_reg : sat_add(first_total_reg, q_pop);
        union_next       = (q_bad || t_bad) ? union_reg : sat_add(union_reg, or_pop);
        common_next      = (q_bad || t_bad) ? common_reg : sat_add(common_reg, and_pop);
        broken_next      = broken_reg;
        bab_next         = bab_reg;
        // first position where the query has a bit the target lacks
        if (!broken_reg && ((q_dec & t_dec) != q_dec)) begin
            broken_next = 1'b1;
            bab_next    = bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bad_reg         <= 1'b0;
            first_bad_reg   <= 1'b0;
            first_total_reg <= '0;
            union_reg       <= '0;
            common_reg      <= '0;
            broken_reg      <= 1'b0;
            bab_reg         <= 1'b0;
        end else if (cmd.accept) begin
            if (cmd.last) begin
                // start a new run
                bad_reg         <= 1'b0;
                first_bad_reg   <= 1'b0;
                first_total_reg <= '0;
                union_reg       <= '0;
                common_reg      <= '0;
                broken_reg      <= 1'b0;
                bab_reg         <= 1'b0;
            end else begin
                bad_reg         <= bad_next;
                first_bad_reg   <= first_bad_next;
                first_total_reg <= first_total_next;
                union_reg       <= union_next;
                common_reg      <= common_next;
                broken_reg      <= broken_next;
                bab_reg         <= bab_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && cmd.last) begin
            fin_mode_reg        <= mode_reg;
            fin_bad_reg         <= bad_next;
            fin_first_bad_reg   <= first_bad_next;
            fin_first_total_reg <= first_total_next;
            fin_common_reg      <= common_next;
            fin_union_reg       <= union_next;
            fin_broken_reg      <= broken_next;
            fin_bab_reg         <= bab_next;
        end
    end

    assign status.skip_div = (fin_mode_reg != hfc_pkg::MODE_TANIMOTO) || fin_bad_reg
                             || (fin_union_reg == '0);

    // restoring division of common * 2^16 by union, one quotient bit per step
    always_comb begin
        rem_sub  = rem_reg - (CNT_W + 1)'(fin_union_reg);
        quo_bit  = (rem_reg >= (CNT_W + 1)'(fin_union_reg));
        rem_next = quo_bit ? {rem_sub[CNT_W-1:0], 1'b0} : {rem_reg[CNT_W-1:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && cmd.last) begin
            rem_reg <= (CNT_W + 1)'(common_next);
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[hfc_pkg::QUO_W-2:0], quo_bit};
        end
    end

    always_comb begin
        res_inv = 1'b0;
        res_cnt = '0;
        res_sim = '0;
        res_sub = 1'b0;
        unique case (fin_mode_reg)
            hfc_pkg::MODE_VALID: begin
                res_inv = fin_first_bad_reg;
                res_sub = !fin_first_bad_reg;
            end
            hfc_pkg::MODE_POPCOUNT: begin
                res_inv = fin_first_bad_reg;
                res_cnt = fin_first_bad_reg ? '0 : to_out(fin_first_total_reg);
            end
            hfc_pkg::MODE_INTERSECT: begin
                res_inv = fin_bad_reg;
                res_cnt = fin_bad_reg ? '0 : to_out(fin_common_reg);
            end
            hfc_pkg::MODE_TANIMOTO: begin
                res_inv = fin_bad_reg;
                res_sim = status.skip_div ? '0 : quo_reg;
            end
            hfc_pkg::MODE_SUBSET: begin
                if (fin_broken_reg) begin
                    res_inv = fin_bab_reg;
                end else begin
                    res_inv = fin_bad_reg;
                    res_sub = !fin_bad_reg;
                end
            end
            default: begin
                res_inv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            invalid    <= res_inv;
            bit_count  <= res_cnt;
            similarity <= res_sim;
            is_subset  <= res_sub;
        end
    end

endmodule

`default_nettype wire
